// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AST_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define AST_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/cpef_pkg.sv =====
// ----------------------------------------------------------------------------
// cpef_pkg
// Types and constants shared by the comment/pattern extract filter.
// ----------------------------------------------------------------------------
package cpef_pkg;

    localparam int WIN_LEN     = 7;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_A      = 8'h61;

    // "__match"
    localparam logic [7:0] MATCH_WORD [WIN_LEN] =
        '{8'h5F, 8'h5F, 8'h6D, 8'h61, 8'h74, 8'h63, 8'h68};

    typedef enum logic [2:0] {
        MODE_ENTRY,
        MODE_LINE,
        MODE_BLOCK,
        MODE_PASS,
        MODE_STR,
        MODE_CHR
    } t_mode;

    typedef enum logic [1:0] {
        OP_EMPTY,   // no bytes, only closes a flush run
        OP_ONE,     // one byte from data
        OP_TWO,     // two spaces
        OP_MATCH    // "  match"
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       ovf;
        logic       step_end;   // last op of the input transfer
        logic       text_end;   // last op of the whole text
    } t_op;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // replacement text "  match", one byte per index
    function automatic logic [7:0] match_repl(input logic [2:0] idx);
        logic [7:0] b;
        b = CH_SPACE;
        if (idx >= 3'd2 && idx < 3'(WIN_LEN)) begin
            b = MATCH_WORD[idx];
        end
        return b;
    endfunction

endpackage

// ===== src/cpef_front.sv =====
// ----------------------------------------------------------------------------
// cpef_front
// Lookahead window and scanner: classifies one text position per cycle while the queue has
// room and queues any emit op it makes (raw bytes when cleaning is off). Holds the mode, skip count and nesting stack.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpef_front #(
    parameter int MATCH_NEST_DEPTH = 8,
    parameter int PAREN_COUNT_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_clean_enable,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_in_byte,
    input  logic            i_in_last,
    input  logic            i_q_full,
    output logic            o_q_push,
    output cpef_pkg::t_op   o_q_op
);

    localparam int SP_W  = $clog2(MATCH_NEST_DEPTH + 1);
    localparam int IDX_W = (MATCH_NEST_DEPTH > 1) ? $clog2(MATCH_NEST_DEPTH) : 1;
    localparam int WL    = cpef_pkg::WIN_LEN;
    localparam logic signed [PAREN_COUNT_BITS-1:0] CNT_MAX =
        {1'b0, {(PAREN_COUNT_BITS-1){1'b1}}};
    localparam logic signed [PAREN_COUNT_BITS-1:0] CNT_MIN =
        {1'b1, {(PAREN_COUNT_BITS-1){1'b0}}};
    localparam logic signed [PAREN_COUNT_BITS-1:0] CNT_ONE = PAREN_COUNT_BITS'(1);
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(MATCH_NEST_DEPTH);

    logic                               r_clean;
    logic [7:0]                         r_win [WL];
    logic [2:0]                         r_fill;
    logic [7:0]                         r_prev;
    cpef_pkg::t_mode                    r_mode;
    logic [2:0]                         r_skip;
    logic signed [PAREN_COUNT_BITS-1:0] r_stack [MATCH_NEST_DEPTH];
    logic [SP_W-1:0]                    r_sp;
    logic                               r_flush;
    logic [2:0]                         r_rem;

    logic       in_acc, proc_norm, proc_flush, proc, flush_final;
    logic [7:0] w [WL];
    logic [2:0] rem;
    logic [7:0] c0, c1, c2, cm1;
    logic       m7;

    cpef_pkg::t_mode                    n_mode;
    logic [2:0]                         n_skip;
    logic [SP_W-1:0]                    n_sp;
    logic                               st_we;
    logic [IDX_W-1:0]                   st_wa, top_idx;
    logic signed [PAREN_COUNT_BITS-1:0] st_wd, top, cnt;
    cpef_pkg::t_kind                    k_kind;
    logic [7:0]                         k_data;
    logic                               k_ovf;
    logic [7:0]                         quote;
    logic [SP_W-1:0]                    sp_dec;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_flush && !i_q_full;
    assign in_acc      = i_in_valid && o_in_ready;
    assign proc_norm   = in_acc && r_clean && !i_in_last && (r_fill == 3'(WL - 1));
    assign proc_flush  = r_flush && !i_q_full;
    assign proc        = proc_norm || proc_flush;
    assign flush_final = r_flush && (r_rem == 3'd1);

    // window taps: position under scan is always tap 0
    always_comb begin
        for (int i = 0; i < WL; i++) begin
            w[i] = r_win[i];
        end
        if (!r_flush) begin
            w[WL-1] = i_in_byte;
        end
        rem = r_flush ? r_rem : 3'(WL);
        c0  = w[0];
        c1  = (rem > 3'd1) ? w[1] : 8'h00;
        c2  = (rem > 3'd2) ? w[2] : 8'h00;
        cm1 = flush_final ? cpef_pkg::CH_A : r_prev;
        m7  = (rem == 3'(WL));
        for (int i = 0; i < WL; i++) begin
            if (w[i] != cpef_pkg::MATCH_WORD[i]) begin
                m7 = 1'b0;
            end
        end
    end

    assign sp_dec  = r_sp - SP_W'(1);
    assign top_idx = sp_dec[IDX_W-1:0];
    assign top     = r_stack[top_idx];

    // scanner for one position
    always_comb begin
        n_mode = r_mode;
        n_skip = r_skip;
        n_sp   = r_sp;
        st_we  = 1'b0;
        st_wa  = top_idx;
        st_wd  = top;
        cnt    = top;
        k_kind = cpef_pkg::OP_EMPTY;
        k_data = cpef_pkg::CH_SPACE;
        k_ovf  = 1'b0;
        quote  = (r_mode == cpef_pkg::MODE_STR) ? cpef_pkg::CH_DQUOTE : cpef_pkg::CH_SQUOTE;
        if (r_skip != 3'd0) begin
            n_skip = r_skip - 3'd1;
        end else begin
            case (r_mode)
                cpef_pkg::MODE_LINE: begin
                    k_kind = cpef_pkg::OP_ONE;
                    if (c0 == cpef_pkg::CH_LF) begin
                        k_data = c0;
                        n_mode = cpef_pkg::MODE_ENTRY;
                    end
                end
                cpef_pkg::MODE_BLOCK: begin
                    k_kind = cpef_pkg::OP_ONE;
                    if (c0 == cpef_pkg::CH_LF || c0 == cpef_pkg::CH_CR) begin
                        k_data = c0;
                    end else if (c0 == cpef_pkg::CH_STAR && c1 == cpef_pkg::CH_SLASH) begin
                        k_kind = cpef_pkg::OP_TWO;
                        n_mode = cpef_pkg::MODE_ENTRY;
                    end
                end
                cpef_pkg::MODE_PASS: begin
                    if (c0 == cpef_pkg::CH_STAR && c1 == cpef_pkg::CH_SLASH) begin
                        k_kind = cpef_pkg::OP_TWO;
                        n_skip = 3'd1;
                        n_mode = cpef_pkg::MODE_ENTRY;
                    end else begin
                        k_kind = cpef_pkg::OP_ONE;
                        k_data = c0;
                    end
                end
                cpef_pkg::MODE_STR, cpef_pkg::MODE_CHR: begin
                    if (c0 == cpef_pkg::CH_BSLASH && c1 == quote) begin
                        k_kind = cpef_pkg::OP_TWO;
                        n_skip = 3'd1;
                    end else begin
                        k_kind = cpef_pkg::OP_ONE;
                        if (c0 == quote) begin
                            n_mode = cpef_pkg::MODE_ENTRY;
                        end
                    end
                end
                default: begin
                    n_mode = cpef_pkg::MODE_ENTRY;
                    if (c0 == cpef_pkg::CH_SLASH && c1 == cpef_pkg::CH_SLASH) begin
                        // first slash of a line comment emits nothing
                        n_mode = cpef_pkg::MODE_LINE;
                    end else if (c0 == cpef_pkg::CH_SLASH && c1 == cpef_pkg::CH_STAR &&
                                 c2 == cpef_pkg::CH_BAR) begin
                        k_kind = cpef_pkg::OP_TWO;
                        n_skip = 3'd1;
                        n_mode = cpef_pkg::MODE_PASS;
                    end else begin
                        if (c0 == cpef_pkg::CH_SLASH && c1 == cpef_pkg::CH_STAR) begin
                            n_mode = cpef_pkg::MODE_BLOCK;
                        end
                        if (!cpef_pkg::is_alnum(cm1) && m7) begin
                            k_kind = cpef_pkg::OP_MATCH;
                            n_skip = 3'(WL - 1);
                            if (r_sp < SP_FULL) begin
                                st_we = 1'b1;
                                st_wa = r_sp[IDX_W-1:0];
                                st_wd = '0;
                                n_sp  = r_sp + SP_W'(1);
                            end else begin
                                k_ovf = 1'b1;
                            end
                        end else if (c0 == cpef_pkg::CH_CR || c0 == cpef_pkg::CH_LF) begin
                            k_kind = cpef_pkg::OP_ONE;
                            k_data = c0;
                        end else begin
                            k_kind = cpef_pkg::OP_ONE;
                            if (c0 == cpef_pkg::CH_DQUOTE) begin
                                n_mode = cpef_pkg::MODE_STR;
                            end
                            if (c0 == cpef_pkg::CH_SQUOTE) begin
                                n_mode = cpef_pkg::MODE_CHR;
                            end
                            if (c0 == cpef_pkg::CH_LPAREN && r_sp != '0) begin
                                if (top >= CNT_MAX) begin
                                    k_ovf = 1'b1;
                                end else begin
                                    cnt = top + CNT_ONE;
                                end
                                st_we = 1'b1;
                                st_wd = cnt;
                                if (cnt == CNT_ONE) begin
                                    k_data = cpef_pkg::CH_LPAREN;
                                end
                            end else if (c0 == cpef_pkg::CH_RPAREN && r_sp != '0) begin
                                if (top <= CNT_MIN) begin
                                    k_ovf = 1'b1;
                                end else begin
                                    cnt = top - CNT_ONE;
                                end
                                st_we = 1'b1;
                                st_wd = cnt;
                                if (cnt == '0) begin
                                    k_data = cpef_pkg::CH_RPAREN;
                                    n_sp   = sp_dec;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    // op to the queue
    always_comb begin
        o_q_push        = 1'b0;
        o_q_op.kind     = k_kind;
        o_q_op.data     = k_data;
        o_q_op.ovf      = k_ovf;
        o_q_op.step_end = 1'b1;
        o_q_op.text_end = 1'b0;
        if (in_acc && !r_clean) begin
            o_q_push        = 1'b1;
            o_q_op.kind     = cpef_pkg::OP_ONE;
            o_q_op.data     = i_in_byte;
            o_q_op.ovf      = 1'b0;
            o_q_op.text_end = i_in_last;
        end else if (proc_norm) begin
            o_q_push = (k_kind != cpef_pkg::OP_EMPTY);
        end else if (proc_flush) begin
            // the final flush position always pushes, even empty, to close the run
            o_q_push        = (k_kind != cpef_pkg::OP_EMPTY) || flush_final;
            o_q_op.step_end = flush_final;
            o_q_op.text_end = flush_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clean <= 1'b1;
            r_fill  <= '0;
            r_prev  <= cpef_pkg::CH_A;
            r_mode  <= cpef_pkg::MODE_ENTRY;
            r_skip  <= '0;
            r_sp    <= '0;
            r_flush <= 1'b0;
            r_rem   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_clean <= i_cfg_clean_enable;
            end
            if (in_acc) begin
                if (!r_clean) begin
                    if (i_in_last) begin
                        r_fill <= '0;
                        r_prev <= cpef_pkg::CH_A;
                        r_mode <= cpef_pkg::MODE_ENTRY;
                        r_skip <= '0;
                        r_sp   <= '0;
                    end
                end else if (i_in_last) begin
                    r_flush <= 1'b1;
                    r_rem   <= r_fill + 3'd1;
                end else if (r_fill != 3'(WL - 1)) begin
                    r_fill <= r_fill + 3'd1;
                end
            end
            if (proc) begin
                r_mode <= n_mode;
                r_skip <= n_skip;
                r_sp   <= n_sp;
                r_prev <= c0;
                if (r_flush) begin
                    r_rem <= r_rem - 3'd1;
                    if (flush_final) begin
                        r_flush <= 1'b0;
                        r_fill  <= '0;
                        r_prev  <= cpef_pkg::CH_A;
                        r_mode  <= cpef_pkg::MODE_ENTRY;
                        r_skip  <= '0;
                        r_sp    <= '0;
                    end
                end
            end
        end
    end

    // window storage, no reset needed: taps past the fill are masked
    always_ff @(posedge i_clk) begin
        if (in_acc && r_clean) begin
            if (!i_in_last && r_fill == 3'(WL - 1)) begin
                for (int i = 0; i < WL - 2; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WL-2] <= i_in_byte;
            end else begin
                r_win[r_fill] <= i_in_byte;
            end
        end else if (proc_flush) begin
            for (int i = 0; i < WL - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && st_we) begin
            r_stack[st_wa] <= st_wd;
        end
    end

    `AST_NEVER(a_sp_range, i_clk, i_rst_n, r_sp > SP_FULL, "nesting pointer past depth")
    `AST_PROP(a_flush_rem, i_clk, i_rst_n, r_flush |-> (r_rem != 3'd0), "flush with no bytes left")
    `AST_PROP(a_flush_clears, i_clk, i_rst_n, (proc_flush && flush_final) |=> (r_sp == '0 && r_skip == 3'd0 && r_fill == 3'd0 && !r_flush), "scan state not cleared after flush")

endmodule

// ===== src/cpef_queue.sv =====
// ----------------------------------------------------------------------------
// cpef_queue
// Short op queue between scanner and emitter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpef_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cpef_pkg::t_op   i_op,
    output logic            o_full,
    output logic            o_valid,
    output cpef_pkg::t_op   o_op,
    input  logic            i_pop
);

    localparam int DEPTH = cpef_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpef_pkg::t_op    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    `AST_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full op queue")

endmodule

// ===== src/cpef_back.sv =====
// ----------------------------------------------------------------------------
// cpef_back
// Emitter: expands queued ops into output bytes, one per cycle while the output is free. A one-entry
// hold stage keeps the newest byte until it is known whether it ends a run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpef_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  cpef_pkg::t_op   i_q_op,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_text_end,
    output logic            o_nest_overflow
);

    logic [2:0] r_idx;
    logic       r_h_v, r_h_res, r_h_last, r_h_end, r_h_ovf;
    logic [7:0] r_h_byte;
    logic       r_out_v, r_out_last, r_out_end, r_out_ovf;
    logic [7:0] r_out_byte;

    logic       is_byte, is_mark, is_tail, o_free, h_release, h_take;
    logic [2:0] tail;
    logic [7:0] gen;

    always_comb begin
        case (i_q_op.kind)
            cpef_pkg::OP_ONE: begin
                tail = 3'd0;
                gen  = i_q_op.data;
            end
            cpef_pkg::OP_TWO: begin
                tail = 3'd1;
                gen  = cpef_pkg::CH_SPACE;
            end
            cpef_pkg::OP_MATCH: begin
                tail = 3'(cpef_pkg::WIN_LEN - 1);
                gen  = cpef_pkg::match_repl(r_idx);
            end
            default: begin
                tail = 3'd0;
                gen  = cpef_pkg::CH_SPACE;
            end
        endcase
    end

    assign is_byte   = i_q_valid && (i_q_op.kind != cpef_pkg::OP_EMPTY);
    assign is_mark   = i_q_valid && (i_q_op.kind == cpef_pkg::OP_EMPTY);
    assign is_tail   = (r_idx == tail);
    assign o_free    = !r_out_v || i_out_ready;
    // an unresolved hold goes out once another byte shows up behind it and the output register is free
    assign h_release = r_h_v && o_free && (r_h_res || is_byte);
    assign h_take    = is_byte && (!r_h_v || h_release);
    assign o_q_pop   = is_mark || (h_take && is_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_h_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (h_take) begin
                r_idx <= is_tail ? 3'd0 : r_idx + 3'd1;
            end
            if (h_take) begin
                r_h_v <= 1'b1;
            end else if (h_release) begin
                r_h_v <= 1'b0;
            end
            if (h_release) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_take) begin
            r_h_byte <= gen;
            r_h_ovf  <= i_q_op.ovf;
            r_h_res  <= !is_tail || i_q_op.step_end;
            r_h_last <= is_tail && i_q_op.step_end;
            r_h_end  <= is_tail && i_q_op.text_end;
        end else if (is_mark && r_h_v && !r_h_res) begin
            r_h_res  <= 1'b1;
            r_h_last <= 1'b1;
            r_h_end  <= i_q_op.text_end;
        end
        if (h_release) begin
            r_out_byte <= r_h_byte;
            r_out_ovf  <= r_h_ovf;
            r_out_last <= r_h_last;
            r_out_end  <= r_h_end;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_out_byte      = r_out_byte;
    assign o_run_last      = r_out_last;
    assign o_text_end      = r_out_end;
    assign o_nest_overflow = r_out_ovf;

    `AST_PROP(a_end_is_last, i_clk, i_rst_n, (r_out_v && r_out_end) |-> r_out_last, "text end without run end")
    `AST_NEVER(a_idx_range, i_clk, i_rst_n, r_idx >= 3'(cpef_pkg::WIN_LEN), "expansion index out of range")

endmodule

// ===== src/comment_pattern_extract_filter.sv =====
// Scan: a byte is scanned when six more bytes have arrived (or in the flush after the
// last byte); its ops pass through the op queue, the hold stage and the output register.
// Throughput: one input byte per cycle while the op queue has room; the last byte
// holds input off while the window flushes, one position per cycle with queue room.
// Output runs one result per cycle while out_ready; a "__match" expands to seven bytes.
// Reset: synchronous, active low; clears scan state, queue and output, sets clean_enable.
// ----------------------------------------------------------------------------
// comment_pattern_extract_filter
// Byte-stream source cleaner: blanks comments and literals but passes the text of
// bar-marked block comments, keeps match patterns with their outermost parentheses.
// Scanner and emitter are decoupled by a short op queue.
// ----------------------------------------------------------------------------
module comment_pattern_extract_filter #(
    parameter int MATCH_NEST_DEPTH = 8,
    parameter int PAREN_COUNT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_clean_enable,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_text_end,
    output logic        o_nest_overflow
);

    logic          q_push, q_full, q_valid, q_pop;
    cpef_pkg::t_op q_in_op, q_out_op;

    cpef_front #(
        .MATCH_NEST_DEPTH (MATCH_NEST_DEPTH),
        .PAREN_COUNT_BITS (PAREN_COUNT_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_clean_enable (i_cfg_clean_enable),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_in_byte          (i_in_byte),
        .i_in_last          (i_in_last),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_q_op             (q_in_op)
    );

    cpef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_out_op),
        .i_pop   (q_pop)
    );

    cpef_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_op          (q_out_op),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_text_end      (o_text_end),
        .o_nest_overflow (o_nest_overflow)
    );

endmodule
